// ===== src/differential_drive_pwm_mixer_assert.svh =====
// Assertion macros for the differential-drive PWM mixer.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_PWM_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PWM_MIXER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DDPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ddpm assertion failed");

// Next-cycle implication, checked out of reset.
`define DDPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddpm assertion failed");

`endif

// ===== src/ddpm_pkg.sv =====
// Shared types and constants of the differential-drive PWM mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddpm_pkg;

	localparam int SPEED_LIMIT  = 10;
	localparam int DUTY_STEP    = 102;
	localparam int DEAD_BAND    = 2;
	localparam int SHARP_FROM   = 9;
	localparam int FULL_SCALE   = 10;
	localparam int SHARP_OFFSET = 8;
	// floor(x / 10) == (x * 6554) >> 16 for x up to 7140
	localparam int DIV10_MUL    = 6554;
	localparam int DIV10_SHIFT  = 16;

	localparam int DUTY_W = 10;
	localparam int PROD_W = 13;

	// Steering decisions that ride along with the item.
	typedef struct packed {
		logic back;
		logic right;
		logic left;
		logic sharp;
	} ddpm_dir_t;

	// Stage 1: saturated magnitudes.
	typedef struct packed {
		ddpm_dir_t  dir;
		logic [3:0] spd;
		logic [3:0] mag;
	} ddpm_cls_t;

	// Stage 2: base duty and inner-wheel factor.
	typedef struct packed {
		ddpm_dir_t         dir;
		logic [DUTY_W-1:0] base;
		logic [2:0]        fac;
	} ddpm_base_t;

	// Stage 3: base duty and unscaled inner product.
	typedef struct packed {
		ddpm_dir_t         dir;
		logic [DUTY_W-1:0] base;
		logic [PROD_W-1:0] prod;
	} ddpm_prod_t;

endpackage

`default_nettype wire

// ===== src/ddpm_classify.sv =====
// Stage 1: saturates the requests, classifies the turn, drops idle items.
// Depends on ddpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddpm_classify (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               command,
	input  wire signed [7:0]  speed_request,
	input  wire signed [7:0]  turn_request,
	output logic              dn_valid,
	input  wire               dn_ready,
	output ddpm_pkg::ddpm_cls_t dn_data
);
	import ddpm_pkg::*;

	logic        valid_s1;
	ddpm_cls_t   data_s1;
	ddpm_cls_t   cls;
	logic        drop;
	logic signed [4:0] spd_sat;
	logic signed [4:0] trn_sat;
	logic [4:0]  spd_abs;
	logic [4:0]  trn_abs;

	function automatic logic signed [4:0] sat10(input logic signed [7:0] v);
		if (v > 8'sd10)
			return 5'sd10;
		else if (v < -8'sd10)
			return -5'sd10;
		else
			return v[4:0];
	endfunction

	always_comb begin
		spd_sat = sat10(speed_request);
		trn_sat = sat10(turn_request);
		spd_abs = spd_sat[4] ? 5'(-spd_sat) : 5'(spd_sat);
		trn_abs = trn_sat[4] ? 5'(-trn_sat) : 5'(trn_sat);
		drop = !command && (speed_request == 8'sd0) && (turn_request == 8'sd0);

		cls.dir.back  = speed_request[7];
		cls.dir.right = turn_request > 8'(DEAD_BAND);
		cls.dir.left  = turn_request < -8'sd2;
		cls.mag       = trn_abs[3:0];
		cls.dir.sharp = trn_abs[3:0] >= 4'(SHARP_FROM);
		// a stop is a zero-speed item: every duty comes out zero
		cls.spd       = command ? 4'd0 : spd_abs[3:0];
	end

	assign in_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid && !drop;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= cls;
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

`default_nettype wire

// ===== src/ddpm_scale.sv =====
// Stages 2 and 3: base duty from speed, then base times inner-wheel factor.
// Depends on ddpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddpm_scale (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  up_valid,
	output logic                 up_ready,
	input  ddpm_pkg::ddpm_cls_t  up_data,
	output logic                 dn_valid,
	input  wire                  dn_ready,
	output ddpm_pkg::ddpm_prod_t dn_data
);
	import ddpm_pkg::*;

	logic        valid_s2;
	logic        valid_s3;
	logic        ready_s3;
	ddpm_base_t  data_s2;
	ddpm_prod_t  data_s3;
	ddpm_base_t  nxt2;
	ddpm_prod_t  nxt3;
	logic [10:0] base_full;
	logic [3:0]  slow_fac;
	logic [3:0]  sharp_fac;

	// Stage 2
	always_comb begin
		base_full = {7'd0, up_data.spd} * 11'(DUTY_STEP);
		slow_fac  = 4'(FULL_SCALE) - up_data.mag;
		sharp_fac = up_data.mag - 4'(SHARP_OFFSET);
		nxt2.dir  = up_data.dir;
		nxt2.base = base_full[DUTY_W-1:0];
		if (!up_data.dir.left && !up_data.dir.right)
			nxt2.fac = 3'd0;
		else if (up_data.dir.sharp)
			nxt2.fac = sharp_fac[2:0];
		else
			nxt2.fac = slow_fac[2:0];
	end

	assign ready_s3 = !valid_s3 || dn_ready;
	assign up_ready = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (up_ready)
				valid_s2 <= up_valid;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	// Stage 3
	always_comb begin
		nxt3.dir  = data_s2.dir;
		nxt3.base = data_s2.base;
		nxt3.prod = PROD_W'(data_s2.base) * PROD_W'(data_s2.fac);
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			data_s2 <= nxt2;
		if (ready_s3 && valid_s2)
			data_s3 <= nxt3;
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

`default_nettype wire

// ===== src/ddpm_mix.sv =====
// Stage 4: inner duty (divide by ten or halve) and routing to the four lines.
// Depends on ddpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddpm_mix (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  up_valid,
	output logic                 up_ready,
	input  ddpm_pkg::ddpm_prod_t up_data,
	output logic                 dn_valid,
	input  wire                  dn_ready,
	output logic [9:0]           lf_duty,
	output logic [9:0]           lr_duty,
	output logic [9:0]           rf_duty,
	output logic [9:0]           rr_duty
);
	import ddpm_pkg::*;

	localparam int RECIP_W = PROD_W + PROD_W;

	logic                valid_s4;
	logic [DUTY_W-1:0]   lf_s4, lr_s4, rf_s4, rr_s4;
	logic [RECIP_W-1:0]  recip;
	logic [DUTY_W-1:0]   inner;
	logic [DUTY_W-1:0]   l_dir, l_opp, r_dir, r_opp;

	always_comb begin
		recip = RECIP_W'(up_data.prod) * RECIP_W'(DIV10_MUL);
		if (up_data.dir.sharp)
			inner = up_data.prod[DUTY_W:1];
		else
			inner = recip[DIV10_SHIFT +: DUTY_W];

		l_dir = '0;
		l_opp = '0;
		r_dir = '0;
		r_opp = '0;
		if (!up_data.dir.left && !up_data.dir.right) begin
			l_dir = up_data.base;
			r_dir = up_data.base;
		end else if (up_data.dir.right) begin
			l_dir = up_data.base;
			if (up_data.dir.sharp)
				r_opp = inner;
			else
				r_dir = inner;
		end else begin
			r_dir = up_data.base;
			if (up_data.dir.sharp)
				l_opp = inner;
			else
				l_dir = inner;
		end
	end

	assign up_ready = !valid_s4 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (up_ready)
			valid_s4 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lf_s4 <= up_data.dir.back ? l_opp : l_dir;
			lr_s4 <= up_data.dir.back ? l_dir : l_opp;
			rf_s4 <= up_data.dir.back ? r_opp : r_dir;
			rr_s4 <= up_data.dir.back ? r_dir : r_opp;
		end
	end

	assign dn_valid = valid_s4;
	assign lf_duty  = lf_s4;
	assign lr_duty  = lr_s4;
	assign rf_duty  = rf_s4;
	assign rr_duty  = rr_s4;

endmodule

`default_nettype wire

// ===== src/differential_drive_pwm_mixer.sv =====
// Top level of the differential-drive PWM mixer.
// Depends on ddpm_pkg, ddpm_classify, ddpm_scale, ddpm_mix and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "differential_drive_pwm_mixer_assert.svh"

// Differential-drive PWM mixer. Takes one item per cycle (command, signed speed,
// signed turn) and returns four 10-bit PWM duties: forward and reverse for the
// left and right motors. Speed and turn saturate to +-10; base duty is
// |speed| * 102. Turns within +-2 drive straight, +-3..8 slow the inner wheel to
// base*(10-|turn|)/10, +-9..10 reverse the inner wheel at (|turn|-8)*base/2;
// everything truncates. A stop item gives all zeros; a motion item with both
// requests zero is consumed and gives no result. There are four register stages
// (classify, base duty, product, divide and route), and out_valid comes from the
// last of them; the sustained rate is one item per clock while out_ready is
// held high. Every stage holds its item while the next one is full, so a stall
// on out_ready backs up through in_ready without loss or duplication. No
// configuration, no state between items.
module differential_drive_pwm_mixer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire              command,
	input  wire signed [7:0] speed_request,
	input  wire signed [7:0] turn_request,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [9:0]       left_forward_duty,
	output logic [9:0]       left_reverse_duty,
	output logic [9:0]       right_forward_duty,
	output logic [9:0]       right_reverse_duty
);
	import ddpm_pkg::*;

	logic       cls_valid, cls_ready;
	ddpm_cls_t  cls_data;
	logic       prod_valid, prod_ready;
	ddpm_prod_t prod_data;

	// stage 1: saturate, classify, drop idle items
	ddpm_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.speed_request (speed_request),
		.turn_request  (turn_request),
		.dn_valid      (cls_valid),
		.dn_ready      (cls_ready),
		.dn_data       (cls_data)
	);

	// stages 2-3: base duty, then base times inner factor
	ddpm_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cls_valid),
		.up_ready (cls_ready),
		.up_data  (cls_data),
		.dn_valid (prod_valid),
		.dn_ready (prod_ready),
		.dn_data  (prod_data)
	);

	// stage 4: divide / halve and route to lines; output register
	ddpm_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prod_valid),
		.up_ready (prod_ready),
		.up_data  (prod_data),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.lf_duty  (left_forward_duty),
		.lr_duty  (left_reverse_duty),
		.rf_duty  (right_forward_duty),
		.rr_duty  (right_reverse_duty)
	);

	// A motor never drives both of its lines at once.
	`DDPM_ASSERT_NOW(a_left_exclusive, out_valid,
		left_forward_duty == 10'd0 || left_reverse_duty == 10'd0)
	`DDPM_ASSERT_NOW(a_right_exclusive, out_valid,
		right_forward_duty == 10'd0 || right_reverse_duty == 10'd0)
	// Duties never exceed the full base duty of 1020.
	`DDPM_ASSERT_NOW(a_duty_max, out_valid,
		left_forward_duty <= 10'd1020 && left_reverse_duty <= 10'd1020 &&
		right_forward_duty <= 10'd1020 && right_reverse_duty <= 10'd1020)
	// Back-pressure only starts from a stalled output.
	`DDPM_ASSERT_NOW(a_stall_origin, !in_ready, out_valid && !out_ready)
	// A product held in stage 3 during a stall does not change.
	`DDPM_ASSERT_NEXT(a_s3_hold, prod_valid && !prod_ready,
		prod_valid && $stable(prod_data))

endmodule

`default_nettype wire

// ===== test/tb_differential_drive_pwm_mixer.sv =====
// Self-checking testbench for differential_drive_pwm_mixer.
// Needs only the RTL (ddpm_pkg and the mixer sources). A directed table runs first,
// then random items. Both handshakes idle and stall at random.
`timescale 1ns / 1ps

module tb_differential_drive_pwm_mixer;

	// command codes
	localparam logic CMD_MOTION = 1'b0;
	localparam logic CMD_STOP   = 1'b1;

	// duty line indexes
	localparam int LINE_LF = 0;
	localparam int LINE_LR = 1;
	localparam int LINE_RF = 2;
	localparam int LINE_RR = 3;

	// steering arithmetic
	localparam int REQ_LIMIT    = 10;
	localparam int STEP_PER_LSB = 102;
	localparam int STRAIGHT_MAX = 2;
	localparam int PIVOT_FROM   = 9;
	localparam int SCALE_DEN    = 10;
	localparam int PIVOT_BIAS   = 8;

	localparam int RANDOM_ITEMS  = 530;
	localparam int DRAIN_CYCLES  = 12;     // pipeline is four deep
	localparam int RUN_LIMIT_NS  = 4_000_000;

	typedef struct packed {
		logic [9:0] lf;
		logic [9:0] lr;
		logic [9:0] rf;
		logic [9:0] rr;
	} duty_set_t;

	typedef struct packed {
		logic              cmd;
		logic signed [7:0] spd;
		logic signed [7:0] trn;
		logic              typed;  // duties below are the literal answer
		duty_set_t         duties;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              command;
	logic signed [7:0] speed_request;
	logic signed [7:0] turn_request;
	logic              out_valid;
	logic              out_ready;
	logic [9:0]        left_forward_duty;
	logic [9:0]        left_reverse_duty;
	logic [9:0]        right_forward_duty;
	logic [9:0]        right_reverse_duty;

	duty_set_t pending_duties[$];   // expected results, oldest first
	int        mismatches = 0;
	bit        no_idle = 1'b0;      // burst stretches without sender gaps

	differential_drive_pwm_mixer dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.speed_request      (speed_request),
		.turn_request       (turn_request),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.left_forward_duty  (left_forward_duty),
		.left_reverse_duty  (left_reverse_duty),
		.right_forward_duty (right_forward_duty),
		.right_reverse_duty (right_reverse_duty)
	);

	always #5 clk = ~clk;

	// Directed items. Typed rows carry answers readable at a glance; the rest
	// go through the predictor. 8'sh80 is -128.
	stim_row_t directed_rows [24] = '{
		'{CMD_STOP,     8'sd0,     8'sd0, 1'b1, '{10'd0, 10'd0, 10'd0, 10'd0}},
		'{CMD_STOP,   8'sd127,   8'sh80, 1'b1, '{10'd0, 10'd0, 10'd0, 10'd0}},
		'{CMD_STOP,    8'sh80,  8'sd127, 1'b1, '{10'd0, 10'd0, 10'd0, 10'd0}},
		'{CMD_MOTION,   8'sd0,    8'sd0, 1'b0, '0},  // silent item
		'{CMD_MOTION,   8'sd0,    8'sd5, 1'b1, '{10'd0, 10'd0, 10'd0, 10'd0}},
		'{CMD_MOTION,   8'sd0,   8'sh80, 1'b1, '{10'd0, 10'd0, 10'd0, 10'd0}},
		'{CMD_MOTION,  8'sd10,    8'sd0, 1'b1, '{10'd1020, 10'd0, 10'd1020, 10'd0}},
		'{CMD_MOTION, -8'sd10,    8'sd0, 1'b1, '{10'd0, 10'd1020, 10'd0, 10'd1020}},
		'{CMD_MOTION, 8'sd127,    8'sd2, 1'b1, '{10'd1020, 10'd0, 10'd1020, 10'd0}},
		'{CMD_MOTION,  8'sh80,   -8'sd2, 1'b1, '{10'd0, 10'd1020, 10'd0, 10'd1020}},
		'{CMD_MOTION,   8'sd1,    8'sd0, 1'b1, '{10'd102, 10'd0, 10'd102, 10'd0}},
		'{CMD_MOTION,  8'sd10,    8'sd3, 1'b0, '0},
		'{CMD_MOTION,  8'sd10,   -8'sd3, 1'b0, '0},
		'{CMD_MOTION,  8'sd10,    8'sd8, 1'b0, '0},
		'{CMD_MOTION, -8'sd10,   -8'sd8, 1'b0, '0},
		'{CMD_MOTION,  -8'sd7,    8'sd5, 1'b0, '0},
		'{CMD_MOTION,  8'sd10,    8'sd9, 1'b0, '0},
		'{CMD_MOTION,  8'sd10,  8'sd127, 1'b0, '0},
		'{CMD_MOTION, -8'sd10,    8'sd9, 1'b0, '0},
		'{CMD_MOTION, -8'sd10, -8'sd127, 1'b0, '0},
		'{CMD_MOTION,   8'sd3,   -8'sd9, 1'b0, '0},
		'{CMD_MOTION,  -8'sd1,    8'sd1, 1'b0, '0},
		'{CMD_MOTION,  8'sh80,   8'sh80, 1'b0, '0},
		'{CMD_MOTION,   8'sd0,    8'sd0, 1'b0, '0}   // second silent item
	};

	function automatic int saturate_request(input logic signed [7:0] raw);
		int v;
		v = raw;
		if (v > REQ_LIMIT)
			return REQ_LIMIT;
		if (v < -REQ_LIMIT)
			return -REQ_LIMIT;
		return v;
	endfunction

	// Predicts the four duties; returns 0 when the item makes no result.
	function automatic logic mix_duties(input logic cmd, input logic signed [7:0] spd_raw,
			input logic signed [7:0] trn_raw, output duty_set_t duties);
		int spd, trn, base, mag, inner;
		int l_travel, r_travel, l_counter, r_counter;
		logic back, right, left;
		int line [4];
		line = '{0, 0, 0, 0};
		duties = '0;
		if (cmd == CMD_STOP)
			return 1'b1;
		// zero test is on raw fields
		if (spd_raw == 0 && trn_raw == 0)
			return 1'b0;
		spd = saturate_request(spd_raw);
		trn = saturate_request(trn_raw);
		if (spd != 0) begin
			back  = spd < 0;
			right = trn > STRAIGHT_MAX;
			left  = trn < -STRAIGHT_MAX;
			l_travel  = back ? LINE_LR : LINE_LF;
			r_travel  = back ? LINE_RR : LINE_RF;
			l_counter = back ? LINE_LF : LINE_LR;
			r_counter = back ? LINE_RF : LINE_RR;
			base = (back ? -spd : spd) * STEP_PER_LSB;
			mag  = trn < 0 ? -trn : trn;
			if (!left && !right) begin
				line[l_travel] = base;
				line[r_travel] = base;
			end else if (mag < PIVOT_FROM) begin
				// mild turn: inner wheel slowed, same direction
				inner = (base * (SCALE_DEN - mag)) / SCALE_DEN;
				if (right) begin
					line[l_travel] = base;
					line[r_travel] = inner;
				end else begin
					line[r_travel] = base;
					line[l_travel] = inner;
				end
			end else begin
				// sharp turn: inner wheel runs on its opposite line
				inner = ((mag - PIVOT_BIAS) * base) >> 1;
				if (right) begin
					line[l_travel]  = base;
					line[r_counter] = inner;
				end else begin
					line[r_travel]  = base;
					line[l_counter] = inner;
				end
			end
		end
		duties.lf = line[LINE_LF][9:0];
		duties.lr = line[LINE_LR][9:0];
		duties.rf = line[LINE_RF][9:0];
		duties.rr = line[LINE_RR][9:0];
		return 1'b1;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Presents one item, waits for acceptance, files the expectation, may idle.
	task automatic send_item(input logic cmd, input logic signed [7:0] spd,
			input logic signed [7:0] trn, input logic has_result, input duty_set_t want);
		int gap;
		command       <= cmd;
		speed_request <= spd;
		turn_request  <= trn;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (has_result)
			pending_duties.push_back(want);
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until the pipeline has delivered everything.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_duties.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_duty(input string field, input logic [9:0] want,
			input logic [9:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// Result checker: samples at the edge, so values are the pre-edge ones.
	always @(posedge clk) begin
		duty_set_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_duties.size() == 0) begin
				$error("result with no expectation: %0d %0d %0d %0d",
					left_forward_duty, left_reverse_duty,
					right_forward_duty, right_reverse_duty);
				mismatches++;
			end else begin
				want = pending_duties.pop_front();
				check_duty("left_forward_duty", want.lf, left_forward_duty);
				check_duty("left_reverse_duty", want.lr, left_reverse_duty);
				check_duty("right_forward_duty", want.rf, right_forward_duty);
				check_duty("right_reverse_duty", want.rr, right_reverse_duty);
			end
		end
	end

	// Receiver back-pressure: random ready/stall phases, some long ready runs.
	initial begin
		int high_len, low_len;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : pick_gap() + 1;
			low_len  = pick_gap();
			out_ready <= 1'b1;
			repeat (high_len) @(posedge clk);
			if (low_len > 0) begin
				out_ready <= 1'b0;
				repeat (low_len) @(posedge clk);
			end
		end
	end

	// Hard stop if the handshakes hang.
	initial begin
		#(RUN_LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	// Reset, directed table, random items, drain, verdict.
	initial begin
		logic              cmd;
		logic signed [7:0] spd, trn;
		logic              has_result;
		duty_set_t         want;
		int                pick;

		arst_n        = 1'b0;
		in_valid      <= 1'b0;
		command       <= CMD_MOTION;
		speed_request <= '0;
		turn_request  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed) begin
				has_result = 1'b1;
				want = directed_rows[i].duties;
			end else begin
				has_result = mix_duties(directed_rows[i].cmd, directed_rows[i].spd,
					directed_rows[i].trn, want);
			end
			send_item(directed_rows[i].cmd, directed_rows[i].spd, directed_rows[i].trn,
				has_result, want);
		end
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// new idle mode every 64 items; about a quarter run back to back
			if (n % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// hold off now and then until every result is back
			if (n % 150 == 75)
				drain_results();
			pick = $urandom_range(0, 19);
			cmd = CMD_MOTION;
			if (pick < 2) begin
				cmd = CMD_STOP;
				spd = 8'($urandom);
				trn = 8'($urandom);
			end else if (pick == 2) begin
				spd = 8'sd0;
				trn = 8'sd0;
			end else if (pick < 6) begin
				// full field range, mostly saturating
				spd = 8'($urandom);
				trn = 8'($urandom);
			end else begin
				// working range, just past the limits on both sides
				spd = 8'($urandom_range(0, 24));
				spd = spd - 8'sd12;
				trn = 8'($urandom_range(0, 24));
				trn = trn - 8'sd12;
			end
			has_result = mix_duties(cmd, spd, trn, want);
			send_item(cmd, spd, trn, has_result, want);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_duties.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
